>>> design/ecpa_pkg.sv
// shared constants, codes and types for the elliptic-curve point engine
`default_nettype none

package ecpa_pkg;

   // default widths of coordinates and scalar
   localparam int COORD_BITS_DEF  = 8;
   localparam int SCALAR_BITS_DEF = 8;

   // register reset values and the smallest usable modulus
   localparam int MOD_RESET     = 67;
   localparam int CURVE_A_RESET = 2;
   localparam int MOD_MIN       = 3;

   // register file addressing
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_MODULUS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CURVE_A       = 2'd1;

   // request codes
   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_MUL = 1'b1;

   // operations of the shared modular unit
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED_PX,
      ST_RED_PY,
      ST_RED_QX,
      ST_RED_QY,
      ST_RED_A,
      ST_SETUP,
      ST_LOOP,
      ST_CMP,
      ST_DBL_SQ,
      ST_DBL_2T,
      ST_DBL_3T,
      ST_DBL_NUM,
      ST_DBL_DEN,
      ST_ADD_NUM,
      ST_ADD_DEN,
      ST_DEN_CHK,
      ST_EU_CHK,
      ST_EU_DIV,
      ST_EU_MUL,
      ST_EU_SUB,
      ST_SLOPE,
      ST_X_SQ,
      ST_X_DBL2,
      ST_X_DBL3,
      ST_X_SUB1,
      ST_X_SUB2,
      ST_Y_DIFF,
      ST_Y_MUL,
      ST_Y_SUB,
      ST_RESP
   } seq_state_type;

endpackage

`default_nettype wire

>>> design/ecpa_ifs.sv
// request, response and register-write channel interfaces
`default_nettype none

interface ecpa_req_if #(
   parameter int COORD_BITS  = ecpa_pkg::COORD_BITS_DEF,
   parameter int SCALAR_BITS = ecpa_pkg::SCALAR_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [COORD_BITS-1:0]  p_x;
   logic [COORD_BITS-1:0]  p_y;
   logic [COORD_BITS-1:0]  q_x;
   logic [COORD_BITS-1:0]  q_y;
   logic [SCALAR_BITS-1:0] scalar_k;

   modport source (output valid, req_type, p_x, p_y, q_x, q_y, scalar_k, input ready);
   modport sink   (input valid, req_type, p_x, p_y, q_x, q_y, scalar_k, output ready);
endinterface

interface ecpa_rsp_if #(
   parameter int COORD_BITS = ecpa_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] r_x;
   logic [COORD_BITS-1:0] r_y;
   logic                  at_infinity;

   modport source (output valid, r_x, r_y, at_infinity, input ready);
   modport sink   (input valid, r_x, r_y, at_infinity, output ready);
endinterface

interface ecpa_csr_if #(
   parameter int COORD_BITS = ecpa_pkg::COORD_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [ecpa_pkg::CSR_IDX_BITS-1:0]   index;
   logic [COORD_BITS-1:0]               data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/ecpa_alu.sv
// shared modular unit: one-step add/sub, bit-serial modular multiply and divide
`default_nettype none

module ecpa_alu #(
   parameter int W = ecpa_pkg::COORD_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  ecpa_pkg::alu_ctl_type ctl,
   input  wire  [W-1:0]          opa,
   input  wire  [W-1:0]          opb,
   input  wire  [W-1:0]          modulus,
   output logic                  done,
   output logic [W-1:0]          acc,
   output logic [W-1:0]          quo
);

   localparam int CNT_BITS = $clog2(W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   ecpa_pkg::alu_op_type op_ff, op_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         sh_ff, sh_in;
   logic [W-1:0]         d_ff, d_in;
   logic [W-1:0]         m_ff, m_in;

   logic         msb;
   logic [W:0]   dbl_w, dbl_r, add_w;
   logic [W-1:0] mul_nx;
   logic [W:0]   trial;
   logic         ge;
   logic [W-1:0] div_nx;
   logic [W:0]   sum_w, dif_w;
   logic [W-1:0] add_res, sub_res;

   // one multiply step: double mod m, then add the addend when the bit is set
   always_comb begin
      msb    = sh_ff[W-1];
      dbl_w  = {acc_ff, 1'b0};
      dbl_r  = (dbl_w >= {1'b0, m_ff}) ? dbl_w - {1'b0, m_ff} : dbl_w;
      add_w  = dbl_r + (msb ? {1'b0, d_ff} : '0);
      mul_nx = (add_w >= {1'b0, m_ff}) ? W'(add_w - {1'b0, m_ff}) : add_w[W-1:0];
   end

   // one restoring division step
   always_comb begin
      trial  = {acc_ff, msb};
      ge     = (trial >= {1'b0, d_ff});
      div_nx = ge ? W'(trial - {1'b0, d_ff}) : trial[W-1:0];
   end

   // combinational modular add and subtract on reduced operands
   always_comb begin
      sum_w   = {1'b0, opa} + {1'b0, opb};
      add_res = (sum_w >= {1'b0, modulus}) ? W'(sum_w - {1'b0, modulus}) : sum_w[W-1:0];
      dif_w   = {1'b0, opa} + {1'b0, modulus} - {1'b0, opb};
      sub_res = (opa >= opb) ? W'(opa - opb) : dif_w[W-1:0];
   end

   // next values of control and datapath
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      d_in    = d_ff;
      m_in    = m_ff;
      if (ctl.start) begin
         op_in = ctl.op;
         case (ctl.op)
            ecpa_pkg::ALU_ADD: begin
               acc_in  = add_res;
               done_in = 1'b1;
            end
            ecpa_pkg::ALU_SUB: begin
               acc_in  = sub_res;
               done_in = 1'b1;
            end
            ecpa_pkg::ALU_MUL: begin
               acc_in  = '0;
               sh_in   = opb;
               d_in    = opa;
               m_in    = modulus;
               busy_in = 1'b1;
               cnt_in  = '0;
            end
            default: begin
               acc_in  = '0;
               sh_in   = opa;
               d_in    = opb;
               m_in    = modulus;
               busy_in = 1'b1;
               cnt_in  = '0;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == ecpa_pkg::ALU_MUL) begin
            acc_in = mul_nx;
            sh_in  = {sh_ff[W-2:0], 1'b0};
         end else begin
            acc_in = div_nx;
            sh_in  = {sh_ff[W-2:0], ge};
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ecpa_pkg::ALU_ADD;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      d_ff   <= d_in;
      m_ff   <= m_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = sh_ff;

   // a new operation never lands on one in progress
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("alu started while busy");

   // a serial operation ends with a completion pulse
   a_fell_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("alu finished without done");

   // completion lasts one cycle
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("alu done held");

endmodule

`default_nettype wire

>>> design/ec_point_add_scalar_mul.sv
// Affine elliptic-curve point add and scalar multiply over a small prime field.
// req_ch takes one word: req_type selects P+Q (add) or k*P (multiply); the
// coordinates are reduced mod the field modulus first. rsp_ch returns one word
// per request: r_x, r_y and at_infinity (coordinates zero when set). csr_ch
// writes field_modulus (index 0) and curve_a (index 1); write while idle.
// One request is in flight at a time: req_ch.ready is high only when idle, and
// rsp_ch.valid holds with a stable word until the receiver takes it, so a
// stalled receiver stalls the next request.
// W = COORD_BITS. The shared modular unit runs multiply and divide bit-serially
// and add and subtract combinationally. Input reduction comes first. A point
// addition doubles when P = Q and inverts by Euclid, with at most about 1.5*W
// quotient steps. An add request is one point addition; a multiply request is
// k-1 of them (none for k below 2), stopping early at the point at infinity.
// Reset (synchronous, active high) returns to idle and sets field_modulus to
// 67 and curve_a to 2.
`default_nettype none

module ec_point_add_scalar_mul #(
   parameter int COORD_BITS  = ecpa_pkg::COORD_BITS_DEF,
   parameter int SCALAR_BITS = ecpa_pkg::SCALAR_BITS_DEF
) (
   input  wire       clock,
   input  wire       reset,
   ecpa_req_if.sink   req_ch,
   ecpa_rsp_if.source rsp_ch,
   ecpa_csr_if.sink   csr_ch
);

   localparam int W = COORD_BITS;

   ecpa_pkg::seq_state_type state_ff, state_in;
   logic                    wait_ff, wait_in;
   logic [W-1:0]            mod_ff, mod_in;
   logic [W-1:0]            cfa_ff, cfa_in;

   logic [W-1:0]            m_ff, m_in;
   logic [W-1:0]            ax_ff, ax_in, ay_ff, ay_in;
   logic [W-1:0]            bx_ff, bx_in, by_ff, by_in;
   logic [W-1:0]            a_ff, a_in;
   logic [W-1:0]            num_ff, num_in, den_ff, den_in;
   logic [W-1:0]            t_ff, t_in, u_ff, u_in, s_ff, s_in;
   logic [W-1:0]            r0_ff, r0_in, r1_ff, r1_in;
   logic [W-1:0]            e0_ff, e0_in, e1_ff, e1_in, q_ff, q_in;
   logic [SCALAR_BITS-1:0]  i_ff, i_in, k_ff, k_in;
   logic                    type_ff, type_in;
   logic                    dbl_ff, dbl_in;
   logic                    inf_ff, inf_in;

   ecpa_pkg::alu_ctl_type   alu_ctl;
   logic [W-1:0]            alu_a, alu_b;
   logic                    alu_done;
   logic [W-1:0]            alu_acc, alu_quo;
   logic                    step_st;
   logic                    same_pt;
   logic [W-1:0]            q_red;

   // states that run an operation on the shared unit
   assign step_st = state_ff inside {
      ecpa_pkg::ST_RED_PX, ecpa_pkg::ST_RED_PY, ecpa_pkg::ST_RED_QX,
      ecpa_pkg::ST_RED_QY, ecpa_pkg::ST_RED_A, ecpa_pkg::ST_DBL_SQ,
      ecpa_pkg::ST_DBL_2T, ecpa_pkg::ST_DBL_3T, ecpa_pkg::ST_DBL_NUM,
      ecpa_pkg::ST_DBL_DEN, ecpa_pkg::ST_ADD_NUM, ecpa_pkg::ST_ADD_DEN,
      ecpa_pkg::ST_EU_DIV, ecpa_pkg::ST_EU_MUL, ecpa_pkg::ST_EU_SUB,
      ecpa_pkg::ST_SLOPE, ecpa_pkg::ST_X_SQ, ecpa_pkg::ST_X_DBL2,
      ecpa_pkg::ST_X_DBL3, ecpa_pkg::ST_X_SUB1, ecpa_pkg::ST_X_SUB2,
      ecpa_pkg::ST_Y_DIFF, ecpa_pkg::ST_Y_MUL, ecpa_pkg::ST_Y_SUB};

   assign same_pt = (ax_ff == bx_ff) && (ay_ff == by_ff);
   // quotient reduced mod m; it never exceeds m
   assign q_red   = (q_ff == m_ff) ? '0 : q_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ecpa_pkg::ST_IDLE:
            if (req_ch.valid) state_in = ecpa_pkg::ST_RED_PX;
         ecpa_pkg::ST_RED_PX:  if (alu_done) state_in = ecpa_pkg::ST_RED_PY;
         ecpa_pkg::ST_RED_PY:  if (alu_done) state_in = ecpa_pkg::ST_RED_QX;
         ecpa_pkg::ST_RED_QX:  if (alu_done) state_in = ecpa_pkg::ST_RED_QY;
         ecpa_pkg::ST_RED_QY:  if (alu_done) state_in = ecpa_pkg::ST_RED_A;
         ecpa_pkg::ST_RED_A:   if (alu_done) state_in = ecpa_pkg::ST_SETUP;
         ecpa_pkg::ST_SETUP:
            state_in = (type_ff == ecpa_pkg::REQ_MUL) ? ecpa_pkg::ST_LOOP : ecpa_pkg::ST_CMP;
         ecpa_pkg::ST_LOOP:
            state_in = (i_ff < k_ff) ? ecpa_pkg::ST_CMP : ecpa_pkg::ST_RESP;
         ecpa_pkg::ST_CMP:
            state_in = same_pt ? ecpa_pkg::ST_DBL_SQ : ecpa_pkg::ST_ADD_NUM;
         ecpa_pkg::ST_DBL_SQ:  if (alu_done) state_in = ecpa_pkg::ST_DBL_2T;
         ecpa_pkg::ST_DBL_2T:  if (alu_done) state_in = ecpa_pkg::ST_DBL_3T;
         ecpa_pkg::ST_DBL_3T:  if (alu_done) state_in = ecpa_pkg::ST_DBL_NUM;
         ecpa_pkg::ST_DBL_NUM: if (alu_done) state_in = ecpa_pkg::ST_DBL_DEN;
         ecpa_pkg::ST_DBL_DEN: if (alu_done) state_in = ecpa_pkg::ST_DEN_CHK;
         ecpa_pkg::ST_ADD_NUM: if (alu_done) state_in = ecpa_pkg::ST_ADD_DEN;
         ecpa_pkg::ST_ADD_DEN: if (alu_done) state_in = ecpa_pkg::ST_DEN_CHK;
         ecpa_pkg::ST_DEN_CHK:
            state_in = (den_ff == '0) ? ecpa_pkg::ST_RESP : ecpa_pkg::ST_EU_CHK;
         ecpa_pkg::ST_EU_CHK:
            state_in = (r1_ff == '0) ? ecpa_pkg::ST_SLOPE : ecpa_pkg::ST_EU_DIV;
         ecpa_pkg::ST_EU_DIV:  if (alu_done) state_in = ecpa_pkg::ST_EU_MUL;
         ecpa_pkg::ST_EU_MUL:  if (alu_done) state_in = ecpa_pkg::ST_EU_SUB;
         ecpa_pkg::ST_EU_SUB:  if (alu_done) state_in = ecpa_pkg::ST_EU_CHK;
         ecpa_pkg::ST_SLOPE:   if (alu_done) state_in = ecpa_pkg::ST_X_SQ;
         ecpa_pkg::ST_X_SQ:
            if (alu_done) state_in = dbl_ff ? ecpa_pkg::ST_X_DBL2 : ecpa_pkg::ST_X_SUB1;
         ecpa_pkg::ST_X_DBL2:  if (alu_done) state_in = ecpa_pkg::ST_X_DBL3;
         ecpa_pkg::ST_X_DBL3:  if (alu_done) state_in = ecpa_pkg::ST_Y_DIFF;
         ecpa_pkg::ST_X_SUB1:  if (alu_done) state_in = ecpa_pkg::ST_X_SUB2;
         ecpa_pkg::ST_X_SUB2:  if (alu_done) state_in = ecpa_pkg::ST_Y_DIFF;
         ecpa_pkg::ST_Y_DIFF:  if (alu_done) state_in = ecpa_pkg::ST_Y_MUL;
         ecpa_pkg::ST_Y_MUL:   if (alu_done) state_in = ecpa_pkg::ST_Y_SUB;
         ecpa_pkg::ST_Y_SUB:
            if (alu_done) begin
               state_in = (type_ff == ecpa_pkg::REQ_MUL) ? ecpa_pkg::ST_LOOP
                                                        : ecpa_pkg::ST_RESP;
            end
         ecpa_pkg::ST_RESP:
            if (rsp_ch.ready) state_in = ecpa_pkg::ST_IDLE;
         default: state_in = ecpa_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshakes and shared-unit operation select
   always_comb begin
      req_ch.ready       = (state_ff == ecpa_pkg::ST_IDLE);
      rsp_ch.valid       = (state_ff == ecpa_pkg::ST_RESP);
      rsp_ch.r_x         = inf_ff ? '0 : ax_ff;
      rsp_ch.r_y         = inf_ff ? '0 : ay_ff;
      rsp_ch.at_infinity = inf_ff;
      csr_ch.ready       = 1'b1;
      alu_ctl.start      = step_st && !wait_ff;
      alu_ctl.op         = ecpa_pkg::ALU_DIV;
      alu_a              = ax_ff;
      alu_b              = m_ff;
      case (state_ff)
         ecpa_pkg::ST_RED_PX: begin
            alu_ctl.op = ecpa_pkg::ALU_DIV; alu_a = ax_ff;  alu_b = m_ff;
         end
         ecpa_pkg::ST_RED_PY: begin
            alu_ctl.op = ecpa_pkg::ALU_DIV; alu_a = ay_ff;  alu_b = m_ff;
         end
         ecpa_pkg::ST_RED_QX: begin
            alu_ctl.op = ecpa_pkg::ALU_DIV; alu_a = bx_ff;  alu_b = m_ff;
         end
         ecpa_pkg::ST_RED_QY: begin
            alu_ctl.op = ecpa_pkg::ALU_DIV; alu_a = by_ff;  alu_b = m_ff;
         end
         ecpa_pkg::ST_RED_A: begin
            alu_ctl.op = ecpa_pkg::ALU_DIV; alu_a = cfa_ff; alu_b = m_ff;
         end
         ecpa_pkg::ST_DBL_SQ: begin
            alu_ctl.op = ecpa_pkg::ALU_MUL; alu_a = ax_ff;  alu_b = ax_ff;
         end
         ecpa_pkg::ST_DBL_2T: begin
            alu_ctl.op = ecpa_pkg::ALU_ADD; alu_a = t_ff;   alu_b = t_ff;
         end
         ecpa_pkg::ST_DBL_3T: begin
            alu_ctl.op = ecpa_pkg::ALU_ADD; alu_a = u_ff;   alu_b = t_ff;
         end
         ecpa_pkg::ST_DBL_NUM: begin
            alu_ctl.op = ecpa_pkg::ALU_ADD; alu_a = t_ff;   alu_b = a_ff;
         end
         ecpa_pkg::ST_DBL_DEN: begin
            alu_ctl.op = ecpa_pkg::ALU_ADD; alu_a = ay_ff;  alu_b = ay_ff;
         end
         ecpa_pkg::ST_ADD_NUM: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = by_ff;  alu_b = ay_ff;
         end
         ecpa_pkg::ST_ADD_DEN: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = bx_ff;  alu_b = ax_ff;
         end
         ecpa_pkg::ST_EU_DIV: begin
            alu_ctl.op = ecpa_pkg::ALU_DIV; alu_a = r0_ff;  alu_b = r1_ff;
         end
         ecpa_pkg::ST_EU_MUL: begin
            alu_ctl.op = ecpa_pkg::ALU_MUL; alu_a = q_red;  alu_b = e1_ff;
         end
         ecpa_pkg::ST_EU_SUB: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = e0_ff;  alu_b = t_ff;
         end
         ecpa_pkg::ST_SLOPE: begin
            alu_ctl.op = ecpa_pkg::ALU_MUL; alu_a = num_ff; alu_b = e0_ff;
         end
         ecpa_pkg::ST_X_SQ: begin
            alu_ctl.op = ecpa_pkg::ALU_MUL; alu_a = s_ff;   alu_b = s_ff;
         end
         ecpa_pkg::ST_X_DBL2: begin
            alu_ctl.op = ecpa_pkg::ALU_ADD; alu_a = ax_ff;  alu_b = ax_ff;
         end
         ecpa_pkg::ST_X_DBL3: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = t_ff;   alu_b = u_ff;
         end
         ecpa_pkg::ST_X_SUB1: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = t_ff;   alu_b = ax_ff;
         end
         ecpa_pkg::ST_X_SUB2: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = t_ff;   alu_b = bx_ff;
         end
         ecpa_pkg::ST_Y_DIFF: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = ax_ff;  alu_b = num_ff;
         end
         ecpa_pkg::ST_Y_MUL: begin
            alu_ctl.op = ecpa_pkg::ALU_MUL; alu_a = s_ff;   alu_b = t_ff;
         end
         ecpa_pkg::ST_Y_SUB: begin
            alu_ctl.op = ecpa_pkg::ALU_SUB; alu_a = t_ff;   alu_b = ay_ff;
         end
         default: ;
      endcase
   end

   // next values of registers
   always_comb begin
      wait_in = wait_ff;
      mod_in  = mod_ff;
      cfa_in  = cfa_ff;
      m_in    = m_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      bx_in   = bx_ff;
      by_in   = by_ff;
      a_in    = a_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      t_in    = t_ff;
      u_in    = u_ff;
      s_in    = s_ff;
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      e0_in   = e0_ff;
      e1_in   = e1_ff;
      q_in    = q_ff;
      i_in    = i_ff;
      k_in    = k_ff;
      type_in = type_ff;
      dbl_in  = dbl_ff;
      inf_in  = inf_ff;

      // register writes
      if (csr_ch.valid) begin
         case (csr_ch.index)
            ecpa_pkg::CSR_FIELD_MODULUS: mod_in = csr_ch.data;
            ecpa_pkg::CSR_CURVE_A:       cfa_in = csr_ch.data;
            default: ;
         endcase
      end

      // operation in flight on the shared unit
      if (alu_ctl.start) begin
         wait_in = 1'b1;
      end else if (alu_done) begin
         wait_in = 1'b0;
      end

      case (state_ff)
         ecpa_pkg::ST_IDLE:
            if (req_ch.valid) begin
               m_in    = (mod_ff < W'(ecpa_pkg::MOD_MIN)) ? W'(ecpa_pkg::MOD_MIN) : mod_ff;
               type_in = req_ch.req_type;
               ax_in   = req_ch.p_x;
               ay_in   = req_ch.p_y;
               bx_in   = req_ch.q_x;
               by_in   = req_ch.q_y;
               k_in    = req_ch.scalar_k;
            end
         ecpa_pkg::ST_RED_PX:  if (alu_done) ax_in = alu_acc;
         ecpa_pkg::ST_RED_PY:  if (alu_done) ay_in = alu_acc;
         ecpa_pkg::ST_RED_QX:  if (alu_done) bx_in = alu_acc;
         ecpa_pkg::ST_RED_QY:  if (alu_done) by_in = alu_acc;
         ecpa_pkg::ST_RED_A:   if (alu_done) a_in  = alu_acc;
         ecpa_pkg::ST_SETUP: begin
            inf_in = 1'b0;
            // multiply adds P to the running point each round
            if (type_ff == ecpa_pkg::REQ_MUL) begin
               bx_in = ax_ff;
               by_in = ay_ff;
               i_in  = SCALAR_BITS'(1);
            end
         end
         ecpa_pkg::ST_CMP:     dbl_in = same_pt;
         ecpa_pkg::ST_DBL_SQ:  if (alu_done) t_in   = alu_acc;
         ecpa_pkg::ST_DBL_2T:  if (alu_done) u_in   = alu_acc;
         ecpa_pkg::ST_DBL_3T:  if (alu_done) t_in   = alu_acc;
         ecpa_pkg::ST_DBL_NUM: if (alu_done) num_in = alu_acc;
         ecpa_pkg::ST_DBL_DEN: if (alu_done) den_in = alu_acc;
         ecpa_pkg::ST_ADD_NUM: if (alu_done) num_in = alu_acc;
         ecpa_pkg::ST_ADD_DEN: if (alu_done) den_in = alu_acc;
         ecpa_pkg::ST_DEN_CHK:
            // vertical line gives the point at infinity
            if (den_ff == '0) begin
               inf_in = 1'b1;
            end else begin
               r0_in = m_ff;
               r1_in = den_ff;
               e0_in = '0;
               e1_in = W'(1);
            end
         ecpa_pkg::ST_EU_DIV:
            if (alu_done) begin
               q_in  = alu_quo;
               r0_in = r1_ff;
               r1_in = alu_acc;
            end
         ecpa_pkg::ST_EU_MUL:  if (alu_done) t_in = alu_acc;
         ecpa_pkg::ST_EU_SUB:
            if (alu_done) begin
               e0_in = e1_ff;
               e1_in = alu_acc;
            end
         ecpa_pkg::ST_SLOPE:   if (alu_done) s_in   = alu_acc;
         ecpa_pkg::ST_X_SQ:    if (alu_done) t_in   = alu_acc;
         ecpa_pkg::ST_X_DBL2:  if (alu_done) u_in   = alu_acc;
         ecpa_pkg::ST_X_DBL3:  if (alu_done) num_in = alu_acc;
         ecpa_pkg::ST_X_SUB1:  if (alu_done) t_in   = alu_acc;
         ecpa_pkg::ST_X_SUB2:  if (alu_done) num_in = alu_acc;
         ecpa_pkg::ST_Y_DIFF:  if (alu_done) t_in   = alu_acc;
         ecpa_pkg::ST_Y_MUL:   if (alu_done) t_in   = alu_acc;
         ecpa_pkg::ST_Y_SUB:
            if (alu_done) begin
               ax_in = num_ff;
               ay_in = alu_acc;
               i_in  = i_ff + SCALAR_BITS'(1);
            end
         default: ;
      endcase
   end

   // control and register-file state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecpa_pkg::ST_IDLE;
         wait_ff  <= 1'b0;
         mod_ff   <= W'(ecpa_pkg::MOD_RESET);
         cfa_ff   <= W'(ecpa_pkg::CURVE_A_RESET);
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         mod_ff   <= mod_in;
         cfa_ff   <= cfa_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      a_ff    <= a_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      s_ff    <= s_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      e0_ff   <= e0_in;
      e1_ff   <= e1_in;
      q_ff    <= q_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      type_ff <= type_in;
      dbl_ff  <= dbl_in;
      inf_ff  <= inf_in;
   end

   // shared modular unit
   ecpa_alu #(
      .W (W)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (alu_ctl),
      .opa     (alu_a),
      .opb     (alu_b),
      .modulus (m_ff),
      .done    (alu_done),
      .acc     (alu_acc),
      .quo     (alu_quo)
   );

   // never idle and holding a result at once
   a_ready_resp: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request ready while response pending");

   // infinity comes with zero coordinates
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.at_infinity |-> rsp_ch.r_x == '0 && rsp_ch.r_y == '0)
      else $error("infinity with nonzero coordinates");

   // an accepted request starts with operand reduction
   a_accept_reduce: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == ecpa_pkg::ST_RED_PX)
      else $error("accepted request did not start");

   // only one operation at a time on the shared unit
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      alu_ctl.start |-> !wait_ff)
      else $error("shared unit started twice");

endmodule

`default_nettype wire

>>> bench/ec_point_add_scalar_mul_checker.sv
// checker: predicts each point result from accepted request words and compares responses
`timescale 1ns / 1ps

module ec_point_add_scalar_mul_checker (
   input  logic        clock,
   input  logic        reset,
   ecpa_req_if         req_ch,
   ecpa_rsp_if         rsp_ch,
   ecpa_csr_if         csr_ch,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   import ecpa_pkg::*;

   localparam int COORD_W  = COORD_BITS_DEF;
   localparam int SCALAR_W = SCALAR_BITS_DEF;

   typedef struct packed {
      logic [COORD_W-1:0] r_x;
      logic [COORD_W-1:0] r_y;
      logic               at_infinity;
   } point_result_type;

   // shadow copy of the register file
   logic [COORD_W-1:0] modulus_q;
   logic [COORD_W-1:0] curve_a_q;

   point_result_type expected_points[$];

   // field helpers, operands reduced first
   function automatic int unsigned field_add(int unsigned x, int unsigned y, int unsigned m);
      return ((x % m) + (y % m)) % m;
   endfunction

   function automatic int unsigned field_sub(int unsigned x, int unsigned y, int unsigned m);
      int unsigned xr;
      int unsigned yr;
      xr = x % m;
      yr = y % m;
      return (xr >= yr) ? xr - yr : xr + m - yr;
   endfunction

   function automatic int unsigned field_mul(int unsigned x, int unsigned y, int unsigned m);
      return ((x % m) * (y % m)) % m;
   endfunction

   // extended euclid on (m, den): coefficient of den
   function automatic int unsigned field_inverse(int unsigned den, int unsigned m);
      int unsigned r0;
      int unsigned r1;
      int unsigned r2;
      int unsigned s0;
      int unsigned s1;
      int unsigned s2;
      int unsigned quot;
      r0 = m;
      r1 = den;
      s0 = 0;
      s1 = 1 % m;
      while (r1 != 0) begin
         quot = r0 / r1;
         r2   = r0 - quot * r1;
         s2   = field_sub(s0, field_mul(quot, s1, m), m);
         r0   = r1;
         r1   = r2;
         s0   = s1;
         s1   = s2;
      end
      return s0;
   endfunction

   // affine sum of reduced points, 0 when the line is vertical
   function automatic bit point_sum(input int unsigned x1, input int unsigned y1,
                                    input int unsigned x2, input int unsigned y2,
                                    input int unsigned m,
                                    output int unsigned rx, output int unsigned ry);
      int unsigned num;
      int unsigned den;
      int unsigned slope;
      int unsigned x3;
      bit          dbl;
      dbl = (x1 == x2) && (y1 == y2);
      if (dbl) begin
         num = field_add(field_mul(3, field_mul(x1, x1, m), m), curve_a_q, m);
         den = field_add(y1, y1, m);
      end else begin
         num = field_sub(y2, y1, m);
         den = field_sub(x2, x1, m);
      end
      rx = 0;
      ry = 0;
      if (den == 0) return 1'b0;
      slope = field_mul(num, field_inverse(den, m), m);
      if (dbl) x3 = field_sub(field_mul(slope, slope, m), field_add(x1, x1, m), m);
      else     x3 = field_sub(field_sub(field_mul(slope, slope, m), x1, m), x2, m);
      rx = x3;
      ry = field_sub(field_mul(slope, field_sub(x1, x3, m), m), y1, m);
      return 1'b1;
   endfunction

   // expected response word for one request word
   function automatic point_result_type predict_point(logic rtype,
                                                      logic [COORD_W-1:0] px_in,
                                                      logic [COORD_W-1:0] py_in,
                                                      logic [COORD_W-1:0] qx_in,
                                                      logic [COORD_W-1:0] qy_in,
                                                      logic [SCALAR_W-1:0] k_in);
      int unsigned      m;
      int unsigned      px;
      int unsigned      py;
      int unsigned      qx;
      int unsigned      qy;
      int unsigned      k;
      int unsigned      rx;
      int unsigned      ry;
      int unsigned      nx;
      int unsigned      ny;
      bit               ok;
      point_result_type res;
      m  = (modulus_q < MOD_MIN) ? MOD_MIN : modulus_q;
      px = px_in % m;
      py = py_in % m;
      qx = qx_in % m;
      qy = qy_in % m;
      k  = k_in;
      ok = 1'b1;
      if (rtype == REQ_ADD) begin
         ok = point_sum(px, py, qx, qy, m, rx, ry);
      end else begin
         rx = px;
         ry = py;
         for (int unsigned step = 1; step < k; step++) begin
            if (!point_sum(rx, ry, px, py, m, nx, ny)) begin
               ok = 1'b0;
               break;
            end
            rx = nx;
            ry = ny;
         end
      end
      if (!ok) begin
         rx = 0;
         ry = 0;
      end
      res.r_x         = rx[COORD_W-1:0];
      res.r_y         = ry[COORD_W-1:0];
      res.at_infinity = !ok;
      return res;
   endfunction

   // watch the three channels at the rising edge
   always @(posedge clock) begin
      point_result_type want;
      int unsigned      errs;
      errs = 0;
      if (reset) begin
         modulus_q = COORD_W'(MOD_RESET);
         curve_a_q = COORD_W'(CURVE_A_RESET);
         expected_points.delete();
         fail_count <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_FIELD_MODULUS) modulus_q = csr_ch.data;
            else if (csr_ch.index == CSR_CURVE_A) curve_a_q = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready)
            expected_points.push_back(predict_point(req_ch.req_type, req_ch.p_x, req_ch.p_y,
                                                    req_ch.q_x, req_ch.q_y, req_ch.scalar_k));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_points.size() == 0) begin
               $error("response word with no request outstanding");
               errs++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_ch.r_x !== want.r_x) begin
                  $error("r_x mismatch: expected %0d, actual %0d", want.r_x, rsp_ch.r_x);
                  errs++;
               end
               if (rsp_ch.r_y !== want.r_y) begin
                  $error("r_y mismatch: expected %0d, actual %0d", want.r_y, rsp_ch.r_y);
                  errs++;
               end
               if (rsp_ch.at_infinity !== want.at_infinity) begin
                  $error("at_infinity mismatch: expected %0d, actual %0d",
                         want.at_infinity, rsp_ch.at_infinity);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= expected_points.size();
   end

endmodule

>>> bench/ec_point_add_scalar_mul_tb.sv
// testbench top: clock, reset, stimulus and verdict for the point engine
`timescale 1ns / 1ps

module ec_point_add_scalar_mul_tb;
   import ecpa_pkg::*;

   localparam int          COORD_W       = COORD_BITS_DEF;
   localparam int          SCALAR_W      = SCALAR_BITS_DEF;
   localparam int unsigned LIMIT_CYCLES  = 60_000_000;
   localparam int unsigned SETTLE_CYCLES = 50;
   localparam int          PHASES        = 9;
   localparam int          PHASE_ITEMS   = 11;

   // indexes with no register behind them
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int unsigned cur_mod;
   logic [15:0] stall_pattern = '1;
   int unsigned stall_phase   = 0;

   ecpa_req_if req_ch ();
   ecpa_rsp_if rsp_ch ();
   ecpa_csr_if csr_ch ();

   ec_point_add_scalar_mul i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ec_point_add_scalar_mul_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver ready on a pattern that is redrawn whenever the low six bits of stall_phase are zero
   always @(negedge clock) begin
      if (stall_phase[5:0] == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = '1;
            1:       stall_pattern = 16'($urandom);
            2:       stall_pattern = 16'($urandom & $urandom);
            default: stall_pattern = 16'($urandom | $urandom);
         endcase
      end
      rsp_ch.ready = stall_pattern[stall_phase[3:0]];
      stall_phase++;
   end

   // one request word, with bursts and gaps on the sender side
   task automatic send_point_req(input logic rtype, input logic [COORD_W-1:0] px,
                                 input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] qx,
                                 input logic [COORD_W-1:0] qy, input logic [SCALAR_W-1:0] k);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 4);
         if (gap != 0) req_ch.valid = 1'b0;
         repeat (gap) begin
            // junk on the payload while idle
            req_ch.req_type = 1'($urandom);
            req_ch.p_x      = COORD_W'($urandom);
            req_ch.p_y      = COORD_W'($urandom);
            req_ch.q_x      = COORD_W'($urandom);
            req_ch.q_y      = COORD_W'($urandom);
            req_ch.scalar_k = SCALAR_W'($urandom);
            @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid    = 1'b1;
      req_ch.req_type = rtype;
      req_ch.p_x      = px;
      req_ch.p_y      = py;
      req_ch.q_x      = qx;
      req_ch.q_y      = qy;
      req_ch.scalar_k = k;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_ch.valid = 1'b0;
      burst_left   = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [COORD_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
      if (idx == CSR_FIELD_MODULUS) cur_mod = value;
   endtask

   // coordinate congruent to v, sometimes lifted by one modulus
   function automatic logic [COORD_W-1:0] alias_coord(int unsigned v, int unsigned m);
      int unsigned r;
      r = v % m;
      if ($urandom_range(0, 1) == 1 && r + m <= 255) r += m;
      return r[COORD_W-1:0];
   endfunction

   // random request word: mostly adds with aimed special points, otherwise multiplies
   task automatic send_random_item();
      logic [COORD_W-1:0]  px;
      logic [COORD_W-1:0]  py;
      logic [COORD_W-1:0]  qx;
      logic [COORD_W-1:0]  qy;
      logic [SCALAR_W-1:0] k;
      logic                rtype;
      int unsigned         m;
      int unsigned         pick;
      m     = (cur_mod < MOD_MIN) ? MOD_MIN : cur_mod;
      px    = COORD_W'($urandom_range(0, 255));
      py    = COORD_W'($urandom_range(0, 255));
      qx    = COORD_W'($urandom_range(0, 255));
      qy    = COORD_W'($urandom_range(0, 255));
      k     = SCALAR_W'($urandom_range(0, 255));
      rtype = REQ_ADD;
      pick  = $urandom_range(0, 99);
      if (pick < 15) begin
         // doubling
         qx = alias_coord(px, m);
         qy = alias_coord(py, m);
      end else if (pick < 22) begin
         // q is the negative of p
         qx = alias_coord(px, m);
         qy = alias_coord((m - py % m) % m, m);
      end else if (pick < 27) begin
         // same x only
         qx = alias_coord(px, m);
      end else if (pick >= 60) begin
         rtype = REQ_MUL;
         if (pick < 97) k = SCALAR_W'($urandom_range(0, 12));
      end
      send_point_req(rtype, px, py, qx, qy, k);
   endtask

   int unsigned phase_mod[PHASES];
   int unsigned phase_a[PHASES];

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_ADD;
      req_ch.p_x      = '0;
      req_ch.p_y      = '0;
      req_ch.q_x      = '0;
      req_ch.q_y      = '0;
      req_ch.scalar_k = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_FIELD_MODULUS;
      csr_ch.data     = '0;
      cur_mod         = MOD_RESET;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed part, reset registers: m = 67, a = 2
      send_point_req(REQ_ADD, 8'd1,   8'd2,   8'd3,   8'd4,   8'd0);
      send_point_req(REQ_ADD, 8'd5,   8'd7,   8'd5,   8'd7,   8'd255);
      send_point_req(REQ_ADD, 8'd4,   8'd0,   8'd4,   8'd0,   8'd9);
      send_point_req(REQ_ADD, 8'd10,  8'd5,   8'd10,  8'd62,  8'd0);
      send_point_req(REQ_ADD, 8'd10,  8'd5,   8'd10,  8'd6,   8'd0);
      send_point_req(REQ_ADD, 8'd2,   8'd3,   8'd69,  8'd70,  8'd0);
      send_point_req(REQ_ADD, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0);
      send_point_req(REQ_ADD, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      send_point_req(REQ_ADD, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_point_req(REQ_ADD, 8'd0,   8'd1,   8'd254, 8'd66,  8'd128);
      send_point_req(REQ_MUL, 8'd9,   8'd20,  8'd255, 8'd255, 8'd0);
      send_point_req(REQ_MUL, 8'd9,   8'd20,  8'd0,   8'd0,   8'd1);
      send_point_req(REQ_MUL, 8'd9,   8'd20,  8'd1,   8'd2,   8'd2);
      send_point_req(REQ_MUL, 8'd3,   8'd6,   8'd170, 8'd85,  8'd3);
      send_point_req(REQ_MUL, 8'd4,   8'd0,   8'd0,   8'd0,   8'd2);
      send_point_req(REQ_MUL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_point_req(REQ_MUL, 8'd2,   8'd22,  8'd0,   8'd0,   8'd255);
      send_point_req(REQ_MUL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd128);
      send_point_req(REQ_MUL, 8'd70,  8'd200, 8'd9,   8'd9,   8'd5);
      drain_results();

      // register settings, extremes among them
      phase_mod = '{3, 255, 0, 251, 4, 97, 128, 2, 67};
      phase_a   = '{0, 254, 254, $urandom_range(0, 254), 3, $urandom_range(0, 255), 255, 1, 2};
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(CSR_FIELD_MODULUS, COORD_W'(phase_mod[ph]));
         write_csr(CSR_CURVE_A, COORD_W'(phase_a[ph]));
         if (ph == 5) begin
            // indexes without a register must change nothing
            write_csr(CSR_SPARE_LO, COORD_W'($urandom));
            write_csr(CSR_SPARE_HI, COORD_W'($urandom));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_item();
            // hold the sender until the engine has answered everything
            if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
